// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned IndexSpaceDefault = 65536;
  localparam int unsigned CountWidthDefault = 32;
  localparam int unsigned IndexW            = 16;
  localparam int unsigned SlackW            = 16;
  localparam int unsigned TotalW            = 32;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [SlackW-1:0] SlackReset = SlackW'(1000);

  typedef logic [IndexW-1:0] index_t;

  // one classified beat on its way from the front to the back
  typedef struct packed {
    index_t idx;
    logic   in_range;
  } psc_item_t;

endpackage

// ===== hw/rtl/psc_front.sv =====
module psc_front import psc_pkg::*; #(
  parameter int unsigned INDEX_SPACE = IndexSpaceDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  index_t    seq_index_i,
  input  logic      clearing_i,
  output logic      push_valid_o,
  output psc_item_t push_item_o,
  input  logic      push_ready_i
);

  // wide enough to hold the largest index space plus one
  localparam int unsigned ExtW = 26;

  logic      f_valid_q, f_valid_d;
  psc_item_t f_item_q, f_item_d;
  logic      accept;
  logic      in_range;

  assign in_range   = (ExtW'(seq_index_i) < ExtW'(INDEX_SPACE));
  assign in_ready_o = (!f_valid_q || push_ready_i) && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    f_valid_d = f_valid_q;
    f_item_d  = f_item_q;
    if (accept) begin
      f_valid_d         = 1'b1;
      f_item_d.idx      = seq_index_i;
      f_item_d.in_range = in_range;
    end else if (push_ready_i) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_item_q <= f_item_d;
  end

  assign push_valid_o = f_valid_q;
  assign push_item_o  = f_item_q;

endmodule

// ===== hw/rtl/psc_queue.sv =====
module psc_queue import psc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  psc_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output psc_item_t pop_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  psc_item_t         slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/psc_back.sv =====
module psc_back import psc_pkg::*; #(
  parameter int unsigned INDEX_SPACE = IndexSpaceDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SlackW-1:0] cfg_wdata_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  psc_item_t         pop_item_i,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_duplicate_o,
  output logic              is_reordered_o,
  output logic              loss_suspected_now_o,
  output logic              loss_ever_suspected_o,
  output index_t            highest_index_o,
  output logic [TotalW-1:0] unique_total_o,
  output logic [TotalW-1:0] duplicate_total_o,
  output logic [TotalW-1:0] reordered_total_o
);

  localparam int unsigned AddrW = $clog2(INDEX_SPACE);
  localparam int unsigned SumW  = ((COUNT_WIDTH > IndexW) ? COUNT_WIDTH : IndexW) + 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // seen bitmap, one bit per index
  logic             seen_mem [INDEX_SPACE];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;

  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  logic [SlackW-1:0] slack_q;

  // lookup stage: item plus registered bitmap read
  logic      s1_valid_q, s1_valid_d;
  psc_item_t s1_item_q;
  logic      rd_q;
  logic      fwd_q, fwd_d;
  logic      s1_adv, pop, commit;

  // statistics
  index_t max_q, max_d;
  count_t uniq_q, uniq_d;
  count_t dup_q, dup_d;
  count_t reord_q, reord_d;
  logic   loss_q, loss_d;

  logic   dup, reord, now;

  // result register
  logic   out_valid_q, out_valid_d;
  logic   res_dup_q, res_reord_q, res_now_q;

  assign commit      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_adv      = !s1_valid_q || commit;
  assign pop_ready_o = s1_adv && !clr_busy_q;
  assign pop         = pop_valid_i && pop_ready_o;
  assign clearing_o  = clr_busy_q;

  // the beat committing now writes after this lookup was read: forward it
  assign fwd_d = commit && s1_item_q.in_range && (s1_item_q.idx == pop_item_i.idx);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    mem_we    = clr_busy_q || (commit && s1_item_q.in_range);
    mem_waddr = clr_busy_q ? clr_addr_q : AddrW'(s1_item_q.idx);
    mem_wdata = !clr_busy_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_q <= seen_mem[AddrW'(pop_item_i.idx)];
    end
  end

  always_comb begin
    dup     = 1'b0;
    reord   = 1'b0;
    now     = 1'b0;
    max_d   = max_q;
    uniq_d  = uniq_q;
    dup_d   = dup_q;
    reord_d = reord_q;
    loss_d  = loss_q;
    if (commit && s1_item_q.in_range) begin
      reord = (s1_item_q.idx < max_q);
      if (reord && (reord_q != '1)) begin
        reord_d = reord_q + 1'b1;
      end
      max_d = (s1_item_q.idx > max_q) ? s1_item_q.idx : max_q;
      // test against the unique count from before this beat
      now = (SumW'(max_d) > (SumW'(uniq_q) + SumW'(slack_q)));
      loss_d = loss_q || now;
      dup = rd_q || fwd_q;
      if (dup) begin
        if (dup_q != '1) begin
          dup_d = dup_q + 1'b1;
        end
      end else if (uniq_q != '1) begin
        uniq_d = uniq_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      slack_q     <= SlackReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_q       <= '0;
      uniq_q      <= '0;
      dup_q       <= '0;
      reord_q     <= '0;
      loss_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_addr_q == AddrW'(INDEX_SPACE - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      uniq_q      <= uniq_d;
      dup_q       <= dup_d;
      reord_q     <= reord_d;
      loss_q      <= loss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q <= pop_item_i;
      fwd_q     <= fwd_d;
    end
    if (commit) begin
      res_dup_q   <= dup;
      res_reord_q <= reord;
      res_now_q   <= now;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign is_duplicate_o        = res_dup_q;
  assign is_reordered_o        = res_reord_q;
  assign loss_suspected_now_o  = res_now_q;
  assign loss_ever_suspected_o = loss_q;
  assign highest_index_o       = max_q;
  assign unique_total_o        = TotalW'(uniq_q);
  assign duplicate_total_o     = TotalW'(dup_q);
  assign reordered_total_o     = TotalW'(reord_q);

endmodule

// ===== hw/rtl/packet_sequence_checker_top.sv =====
// Packet sequence checker: one received sequence index per beat on the input
// channel (in_valid_i / in_ready_o / seq_index_i), one result beat per
// input beat on the output channel (out_valid_o / out_ready_i and fields).
// Results give duplicate, reordered and loss flags plus running totals.
// cfg_we_i / cfg_wdata_i write the reorder slack; write it only while idle.
// Throughput: one beat per cycle while out_ready_i is high and no clear runs.
// Each beat passes the front register, queue, lookup stage (registered read
// of the seen bitmap: one write port, one read port) and result register.
// After reset the bitmap is cleared one entry per cycle: in_ready_o stays low
// until all INDEX_SPACE entries (65536 by default) are clear; cfg writes are
// taken meanwhile. Counters saturate; totals show their low 32 bits. Indices
// at or beyond INDEX_SPACE leave the state unchanged and give zero flags.
// A stalled receiver holds the result register; the lookup stage, the
// two-entry queue and the front register keep taking beats until full, then
// in_ready_o drops.
module packet_sequence_checker_top import psc_pkg::*; #(
  parameter int unsigned INDEX_SPACE = IndexSpaceDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SlackW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  index_t            seq_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_duplicate_o,
  output logic              is_reordered_o,
  output logic              loss_suspected_now_o,
  output logic              loss_ever_suspected_o,
  output index_t            highest_index_o,
  output logic [TotalW-1:0] unique_total_o,
  output logic [TotalW-1:0] duplicate_total_o,
  output logic [TotalW-1:0] reordered_total_o
);

  logic      clearing;
  logic      push_valid, push_ready;
  psc_item_t push_item;
  logic      pop_valid, pop_ready;
  psc_item_t pop_item;

  psc_front #(
    .INDEX_SPACE (INDEX_SPACE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .seq_index_i    (seq_index_i),
    .clearing_i     (clearing),
    .push_valid_o   (push_valid),
    .push_item_o    (push_item),
    .push_ready_i   (push_ready)
  );

  psc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  psc_back #(
    .INDEX_SPACE (INDEX_SPACE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .pop_valid_i           (pop_valid),
    .pop_ready_o           (pop_ready),
    .pop_item_i            (pop_item),
    .clearing_o            (clearing),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .is_duplicate_o        (is_duplicate_o),
    .is_reordered_o        (is_reordered_o),
    .loss_suspected_now_o  (loss_suspected_now_o),
    .loss_ever_suspected_o (loss_ever_suspected_o),
    .highest_index_o       (highest_index_o),
    .unique_total_o        (unique_total_o),
    .duplicate_total_o     (duplicate_total_o),
    .reordered_total_o     (reordered_total_o)
  );

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o
  ) else $error("input taken during bitmap clear");

  a_max_monotonic: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |-> (highest_index_o >= $past(highest_index_o))
  ) else $error("highest index went down");

  a_reorder_needs_max: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_reordered_o) |-> (highest_index_o != '0)
  ) else $error("reordered beat with zero maximum");

  a_loss_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && loss_suspected_now_o) |-> loss_ever_suspected_o
  ) else $error("loss seen but sticky flag clear");
`endif

endmodule

// ===== verif/psc_stream_checker.sv =====
`timescale 1ns / 1ps

module psc_stream_checker import psc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SlackW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  index_t            seq_index_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              is_duplicate_i,
  input  logic              is_reordered_i,
  input  logic              loss_suspected_now_i,
  input  logic              loss_ever_suspected_i,
  input  index_t            highest_index_i,
  input  logic [TotalW-1:0] unique_total_i,
  input  logic [TotalW-1:0] duplicate_total_i,
  input  logic [TotalW-1:0] reordered_total_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  localparam int unsigned CntW = CountWidthDefault;

  typedef logic [CntW-1:0] count_t;

  typedef struct packed {
    logic              dup;
    logic              reordered;
    logic              loss_now;
    logic              loss_ever;
    index_t            highest;
    logic [TotalW-1:0] unique_total;
    logic [TotalW-1:0] dup_total;
    logic [TotalW-1:0] reorder_total;
  } stats_t;

  bit                seen_map [IndexSpaceDefault];
  index_t            max_index;
  count_t            unique_cnt;
  count_t            dup_cnt;
  count_t            reorder_cnt;
  logic              loss_sticky;
  logic [SlackW-1:0] slack;
  stats_t            stats_due [$];
  int unsigned       mismatches = 0;

  assign errors_o = mismatches;

  function automatic count_t bump(count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic report(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare(string field, logic [TotalW-1:0] got, logic [TotalW-1:0] want);
    if (got !== want) report($sformatf("%s: got %0d, want %0d", field, got, want));
  endtask

  task automatic track_packet(index_t idx);
    stats_t        s;
    logic [CntW:0] bound;
    s = '0;
    if (32'(idx) < IndexSpaceDefault) begin
      s.reordered = idx < max_index;
      if (s.reordered) reorder_cnt = bump(reorder_cnt);
      if (idx > max_index) max_index = idx;
      // one bit wider so unique count plus slack never wraps
      bound = {1'b0, unique_cnt} + (CntW+1)'(slack);
      s.loss_now = (CntW+1)'(max_index) > bound;
      if (s.loss_now) loss_sticky = 1'b1;
      s.dup = seen_map[idx];
      if (s.dup) dup_cnt = bump(dup_cnt);
      else unique_cnt = bump(unique_cnt);
      seen_map[idx] = 1'b1;
    end
    s.loss_ever     = loss_sticky;
    s.highest       = max_index;
    s.unique_total  = TotalW'(unique_cnt);
    s.dup_total     = TotalW'(dup_cnt);
    s.reorder_total = TotalW'(reorder_cnt);
    stats_due.insert(stats_due.size(), s);
  endtask

  task automatic check_result();
    stats_t want;
    if (stats_due.size() == 0) begin
      report($sformatf("result beat with nothing predicted (highest %0d)", highest_index_i));
      return;
    end
    want = stats_due.pop_front();
    compare("is_duplicate", TotalW'(is_duplicate_i), TotalW'(want.dup));
    compare("is_reordered", TotalW'(is_reordered_i), TotalW'(want.reordered));
    compare("loss_suspected_now", TotalW'(loss_suspected_now_i), TotalW'(want.loss_now));
    compare("loss_ever_suspected", TotalW'(loss_ever_suspected_i), TotalW'(want.loss_ever));
    compare("highest_index", TotalW'(highest_index_i), TotalW'(want.highest));
    compare("unique_total", unique_total_i, want.unique_total);
    compare("duplicate_total", duplicate_total_i, want.dup_total);
    compare("reordered_total", reordered_total_i, want.reorder_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      max_index   = '0;
      unique_cnt  = '0;
      dup_cnt     = '0;
      reorder_cnt = '0;
      loss_sticky = 1'b0;
      slack       = SlackReset;
      stats_due.delete();
      pending_o <= 0;
    end else begin
      // retire the result first so a beat never meets its own prediction
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) slack = cfg_wdata_i;
      if (in_valid_i && in_ready_i) track_packet(seq_index_i);
      pending_o <= stats_due.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import psc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we       = 1'b0;
  logic [SlackW-1:0] cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  index_t            seq_index    = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              is_duplicate;
  logic              is_reordered;
  logic              loss_now;
  logic              loss_ever;
  index_t            highest_index;
  logic [TotalW-1:0] unique_total;
  logic [TotalW-1:0] duplicate_total;
  logic [TotalW-1:0] reordered_total;
  int unsigned       errors;
  int unsigned       pending;
  int unsigned       cycles       = 0;
  int unsigned       cursor       = 3001;
  int                send_run     = 0;
  bit                send_calm    = 1'b0;

  always #5 clk_i = ~clk_i;

  packet_sequence_checker_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .seq_index_i          (seq_index),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .is_duplicate_o       (is_duplicate),
    .is_reordered_o       (is_reordered),
    .loss_suspected_now_o (loss_now),
    .loss_ever_suspected_o(loss_ever),
    .highest_index_o      (highest_index),
    .unique_total_o       (unique_total),
    .duplicate_total_o    (duplicate_total),
    .reordered_total_o    (reordered_total)
  );

  psc_stream_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .seq_index_i          (seq_index),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .is_duplicate_i       (is_duplicate),
    .is_reordered_i       (is_reordered),
    .loss_suspected_now_i (loss_now),
    .loss_ever_suspected_i(loss_ever),
    .highest_index_i      (highest_index),
    .unique_total_i       (unique_total),
    .duplicate_total_i    (duplicate_total),
    .reordered_total_i    (reordered_total),
    .errors_o             (errors),
    .pending_o            (pending)
  );

  // allows for the bitmap clearing pass after reset
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // alternate runs of busy idling with calm runs of back-to-back beats
  task automatic draw_gap(inout int run_left, inout bit calm, output int gap);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    gap = calm ? 0 : $urandom_range(0, 7);
  endtask

  task automatic send_index(index_t idx);
    int gap;
    draw_gap(send_run, send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    seq_index <= idx;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_slack(logic [SlackW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mostly an in-order stream with small gaps, plus late, repeated and stray beats
  task automatic next_index(output index_t idx);
    int unsigned sel;
    int unsigned top;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      idx = index_t'(cursor);
      cursor += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
    end else if (sel < 82) begin
      idx = (cursor > 30) ? index_t'(cursor - $urandom_range(1, 30)) : '0;
    end else if (sel < 92) begin
      idx = (cursor > 0) ? index_t'(cursor - 1) : '0;
    end else begin
      top = (cursor + 400 > 65535) ? 65535 : cursor + 400;
      idx = index_t'($urandom_range(0, top));
      if (idx >= cursor) cursor = idx + 1;
    end
    if (cursor > 65535) cursor = 65535;
  endtask

  initial begin : receiver
    int gap;
    int run_left;
    bit calm;
    @(posedge clk_i);
    forever begin
      draw_gap(run_left, calm, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    index_t            opening [7];
    index_t            tight   [5];
    index_t            loose   [3];
    logic [SlackW-1:0] phase_slack [5];
    index_t            idx;
    opening = '{16'd0, 16'd0, 16'd2, 16'd1, 16'd1, 16'd1500, 16'd1501};
    tight   = '{16'd1502, 16'd1503, 16'd1600, 16'd4, 16'd1600};
    loose   = '{16'd1601, 16'd3000, 16'd5};
    phase_slack = '{16'd7, 16'd200, 16'hFFFF, 16'd0, 16'd0};
    phase_slack[4] = SlackW'($urandom_range(1, 65534));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset slack: first beat, repeat, skip, late beat, late repeat, then a jump raising loss
    foreach (opening[i]) send_index(opening[i]);
    drain();
    set_slack('0);
    foreach (tight[i]) send_index(tight[i]);
    drain();
    set_slack(16'hFFFF);
    foreach (loose[i]) send_index(loose[i]);

    for (int p = 0; p < 5; p++) begin
      drain();
      set_slack(phase_slack[p]);
      repeat (140) begin
        next_index(idx);
        send_index(idx);
      end
    end

    // top of the index space last, since the highest index never comes down
    drain();
    set_slack(SlackReset);
    send_index(16'hFFFF);
    send_index(16'hFFFF);
    send_index(16'hFFFE);
    repeat (50) send_index(index_t'($urandom));
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
